// File: rtl/nmea_gga_sentence_receiver_top_macros.svh
// Assertion macros for the GGA receiver.
`ifndef NMEA_GGA_SENTENCE_RECEIVER_TOP_MACROS_SVH
`define NMEA_GGA_SENTENCE_RECEIVER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, a, c)
`define ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

// File: rtl/ngga_pkg.sv
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared constants and types for the GGA sentence receiver.
// ----------------------------------------------------------------------------
package ngga_pkg;
  localparam int MaxSentence = 80;
  localparam int IdLength    = 5;
  localparam int AddrW       = $clog2(MaxSentence);
  localparam int CntW        = 7;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_SLEEP = 2'd2;
  localparam logic [1:0] REQ_WAKE  = 2'd3;

  localparam logic [1:0] KIND_FIELD = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] GGA_CODE = 8'h56;
  localparam logic [15:0] TimeoutReset = 16'd18000;

  typedef enum logic [5:0] {
    M_WAIT  = 6'b000001,
    M_TYPE  = 6'b000010,
    M_BODY  = 6'b000100,
    M_CK1   = 6'b001000,
    M_CK2   = 6'b010000,
    M_SLEEP = 6'b100000
  } rx_mode_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EMIT = 4'b0100,
    S_TAIL = 4'b1000
  } scan_state_e;

  // controller -> datapath
  typedef struct packed {
    logic       store_we;   // write rx byte at byte count
    logic       clear_cnt;  // start of a sentence
    logic       inc_cnt;
    logic       xor_en;
    logic       ck1_en;
    logic       ck2_en;
    logic       win_load;   // clear byte window to zeros
    logic       win_shift;  // shift in next memory byte
    logic       ptr_clear;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntW-1:0] byte_count;
    logic            ck_match;
    logic            id_ok;
    logic            ptr_done;  // scan pointer reached byte count
    logic            head_comma;
  } dp_sts_t;

  function automatic logic [7:0] hexval(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 8'd10;
    return b - 8'h30;
  endfunction

  function automatic logic [15:0] dg(input logic [7:0] b);
    return {8'h00, b} - 16'd48;
  endfunction
endpackage

// File: rtl/ngga_datapath.sv
// ----------------------------------------------------------------------------
// ngga_datapath
// Sentence store, checksum registers and the scan window with field math.
// ----------------------------------------------------------------------------
module ngga_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  ngga_pkg::dp_cmd_t cmd_i,
  input  logic [3:0]       comma_i,   // comma number of the field at window head
  input  logic [1:0]       sub_i,     // result index within the field
  output ngga_pkg::dp_sts_t sts_o,
  output logic [4:0]       field_id_o,
  output logic [15:0]      field_value_o,
  output logic             has_more_o, // another result in this field
  output logic             emits_o     // this field produces output
);
  import ngga_pkg::*;

  logic [7:0] mem [MaxSentence];
  logic [CntW-1:0] cnt_q, ptr_q;
  logic [7:0] xor_q, ck_q;
  logic [7:0] rdata_q;
  // win[0] is the comma, win[k] is byte at comma+k
  logic [7:0] win_q [11];
  logic [CntW-1:0] wptr_q; // address of next byte to enter window
  logic [7:0] hx;

  assign hx = hexval(rx_byte_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we && cnt_q < CntW'(MaxSentence))
      mem[cnt_q[AddrW-1:0]] <= rx_byte_i;
  end

  // read ahead so rdata_q always holds the byte at wptr_q
  logic [CntW-1:0] raddr;
  assign raddr = cmd_i.ptr_clear ? '0 : (cmd_i.win_shift ? wptr_q + 1'b1 : wptr_q);
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; xor_q <= '0; ck_q <= '0; wptr_q <= '0; ptr_q <= '0;
    end else begin
      if (cmd_i.clear_cnt) begin
        cnt_q <= '0; xor_q <= '0;
      end else begin
        if (cmd_i.inc_cnt) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.xor_en) xor_q <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.ck1_en) ck_q <= {hx[3:0], 4'h0};
      if (cmd_i.ck2_en) ck_q <= ck_q + hx;
      if (cmd_i.ptr_clear) begin
        wptr_q <= '0; ptr_q <= '0;
      end else if (cmd_i.win_shift) begin
        wptr_q <= wptr_q + 1'b1;
        // head address after the shift; wraps during prefill
        ptr_q  <= wptr_q - CntW'(10);
      end
    end
  end

  // window: byte at wptr enters at top; bytes beyond count read as 0
  logic [7:0] in_b;
  logic [CntW-1:0] in_addr_q;
  always_ff @(posedge clk_i) begin
    in_addr_q <= raddr;
  end
  assign in_b = (in_addr_q < cnt_q && in_addr_q < CntW'(MaxSentence)) ? rdata_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      for (int k = 0; k < 11; k++) win_q[k] <= 8'h00;
    end else if (cmd_i.win_shift) begin
      for (int k = 0; k < 10; k++) win_q[k] <= win_q[k+1];
      win_q[10] <= in_b;
    end
  end

  // ck2 compare uses value being written
  logic [7:0] ck_next;
  assign ck_next = ck_q + hx;

  assign sts_o.byte_count = cnt_q;
  assign sts_o.ck_match   = (ck_next == xor_q);
  assign sts_o.id_ok      = ((xor_q ^ rx_byte_i) == GGA_CODE);
  assign sts_o.ptr_done   = (ptr_q >= cnt_q) || (ptr_q >= CntW'(MaxSentence));
  assign sts_o.head_comma = (win_q[0] == CH_COMMA);

  // field math; products by small constants are shift-adds
  logic [15:0] d [11];
  always_comb begin
    for (int k = 0; k < 11; k++) d[k] = dg(win_q[k]);
  end

  always_comb begin
    field_id_o    = 5'd0;
    field_value_o = 16'd0;
    has_more_o    = 1'b0;
    emits_o       = (win_q[1] != CH_COMMA);
    case (comma_i)
      4'd1: begin
        has_more_o = (sub_i != 2'd3);
        field_id_o = {3'b000, sub_i};
        case (sub_i)
          2'd0: field_value_o = d[1]*16'd10 + d[2];
          2'd1: field_value_o = d[3]*16'd10 + d[4];
          2'd2: field_value_o = d[5]*16'd10 + d[6];
          default: field_value_o = d[8]*16'd100 + d[9]*16'd10 + d[10];
        endcase
      end
      4'd2: begin
        has_more_o = (sub_i != 2'd2);
        field_id_o = 5'd4 + {3'b000, sub_i};
        case (sub_i)
          2'd0: field_value_o = d[1]*16'd10 + d[2];
          2'd1: field_value_o = d[3]*16'd10 + d[4];
          default: field_value_o = d[6]*16'd1000 + d[7]*16'd100 + d[8]*16'd10 + d[9];
        endcase
      end
      4'd3: begin field_id_o = 5'd7; field_value_o = {8'h00, win_q[1]}; end
      4'd4: begin
        has_more_o = (sub_i != 2'd2);
        field_id_o = 5'd8 + {3'b000, sub_i};
        case (sub_i)
          2'd0: field_value_o = d[1]*16'd100 + d[2]*16'd10 + d[3];
          2'd1: field_value_o = d[4]*16'd10 + d[5];
          default: field_value_o = d[7]*16'd1000 + d[8]*16'd100 + d[9]*16'd10 + d[10];
        endcase
      end
      4'd5: begin field_id_o = 5'd11; field_value_o = {8'h00, win_q[1]}; end
      4'd6: begin field_id_o = 5'd12; field_value_o = d[1]; end
      4'd7: begin
        field_id_o = 5'd13;
        field_value_o = (win_q[2] != CH_COMMA) ? d[1]*16'd10 + d[2] : d[1];
      end
      4'd8: begin field_id_o = 5'd14; field_value_o = d[1]*16'd100 + d[3]*16'd10 + d[4]; end
      4'd9: begin field_id_o = 5'd15; field_value_o = d[1]*16'd100 + d[2]*16'd10 + d[4]; end
      4'd10: begin field_id_o = 5'd16; field_value_o = {8'h00, win_q[1]}; end
      4'd11: begin field_id_o = 5'd17; field_value_o = d[1]*16'd100 + d[2]*16'd10 + d[4]; end
      4'd12: begin field_id_o = 5'd18; field_value_o = {8'h00, win_q[1]}; end
      default: emits_o = 1'b0;
    endcase
  end
endmodule

// File: rtl/ngga_controller.sv
// ----------------------------------------------------------------------------
// ngga_controller
// Receive mode machine, timeout counter and field scan sequencer.
// ----------------------------------------------------------------------------
module ngga_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output ngga_pkg::dp_cmd_t cmd_o,
  input  ngga_pkg::dp_sts_t sts_i,
  output logic [3:0]        comma_o,
  output logic [1:0]        sub_o,
  input  logic              has_more_i,
  input  logic              emits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic              use_field_o,
  output logic              last_o
);
  import ngga_pkg::*;
  `include "nmea_gga_sentence_receiver_top_macros.svh"

  rx_mode_e mode_q, mode_d;
  scan_state_e sc_q, sc_d;
  logic [15:0] tmo_q, idle_q;
  logic [3:0] comma_q;  // saturates at 13: later commas give nothing
  logic [1:0] sub_q;
  logic [3:0] pre_q;    // window prefill beats
  logic out_v_q;
  logic [1:0] kind_q;
  logic fld_q, last_q;

  logic acc, is_byte, open;
  assign in_ready_o = (sc_q == S_IDLE) && !out_v_q;
  assign acc  = in_valid_i && in_ready_o;
  assign is_byte = (req_type_i == REQ_BYTE);
  assign open = (mode_q == M_TYPE) || (mode_q == M_BODY) || (mode_q == M_CK1)
             || (mode_q == M_CK2);

  logic start_scan, start_err;
  always_comb begin
    mode_d = mode_q;
    cmd_o = '0;
    start_scan = 1'b0;
    start_err  = 1'b0;
    if (acc) begin
      case (req_type_i)
        REQ_SLEEP: mode_d = M_SLEEP;
        REQ_WAKE: if (mode_q == M_SLEEP || mode_q == M_CK2) mode_d = M_WAIT;
        REQ_TICK: if (open && ((idle_q == 16'hFFFF ? idle_q : idle_q + 16'd1) >= tmo_q))
                    mode_d = M_WAIT;
        default: begin
          case (mode_q)
            M_WAIT: if (rx_byte_i == CH_START) begin
              mode_d = M_TYPE; cmd_o.clear_cnt = 1'b1;
            end
            M_TYPE: begin
              cmd_o.store_we = 1'b1; cmd_o.inc_cnt = 1'b1; cmd_o.xor_en = 1'b1;
              if (sts_i.byte_count + 1'b1 >= CntW'(IdLength))
                mode_d = (sts_i.byte_count + 1'b1 == CntW'(IdLength) && sts_i.id_ok)
                         ? M_BODY : M_WAIT;
            end
            M_BODY: begin
              if (rx_byte_i == CH_STAR) mode_d = M_CK1;
              else if (sts_i.byte_count < CntW'(MaxSentence)) begin
                cmd_o.store_we = 1'b1; cmd_o.inc_cnt = 1'b1; cmd_o.xor_en = 1'b1;
              end else mode_d = M_WAIT;
            end
            M_CK1: begin cmd_o.ck1_en = 1'b1; mode_d = M_CK2; end
            M_CK2: begin
              cmd_o.ck2_en = 1'b1; mode_d = M_WAIT;
              if (sts_i.ck_match) start_scan = 1'b1; else start_err = 1'b1;
            end
            M_SLEEP: ;  // bytes are ignored while asleep
            default: mode_d = M_WAIT;
          endcase
        end
      endcase
    end
    // scan sequencer
    sc_d = sc_q;
    case (sc_q)
      S_IDLE: if (start_scan) begin
        sc_d = S_READ; cmd_o.ptr_clear = 1'b1; cmd_o.win_load = 1'b1;
      end
      S_READ: begin
        // prefill window, then advance one byte per beat looking for commas
        if (pre_q < 4'd11) cmd_o.win_shift = 1'b1;
        else if (sts_i.ptr_done) sc_d = S_TAIL;
        else if (sts_i.head_comma && comma_q + 4'd1 <= 4'd12 && emits_i)
          sc_d = S_EMIT;
        else cmd_o.win_shift = 1'b1;
      end
      S_EMIT: if (!out_v_q || out_ready_i) begin
        if (!has_more_i) begin sc_d = S_READ; cmd_o.win_shift = 1'b1; end
      end
      S_TAIL: if (!out_v_q || out_ready_i) sc_d = S_IDLE;
      default: sc_d = S_IDLE;
    endcase
  end

  // a new result beat goes into the output register
  logic out_load;
  assign out_load = start_err ||
                    (((sc_q == S_EMIT) || (sc_q == S_TAIL)) && (!out_v_q || out_ready_i));

  // head is a comma: its number is comma_q+1
  assign comma_o = (sc_q == S_READ) ? comma_q + 4'd1 : comma_q;
  assign sub_o   = sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_WAIT; sc_q <= S_IDLE; tmo_q <= TimeoutReset; idle_q <= '0;
      comma_q <= '0; sub_q <= '0; pre_q <= '0; out_v_q <= 1'b0;
      kind_q <= KIND_FIELD; fld_q <= 1'b0; last_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      sc_q   <= sc_d;
      if (cfg_we_i) tmo_q <= cfg_wdata_i;
      if (acc) begin
        if (req_type_i == REQ_TICK) begin
          if (open) begin
            if ((idle_q == 16'hFFFF ? idle_q : idle_q + 16'd1) >= tmo_q) idle_q <= '0;
            else if (idle_q != 16'hFFFF) idle_q <= idle_q + 16'd1;
          end
        end else if (is_byte && (open || mode_q == M_WAIT)) begin
          if (open || rx_byte_i == CH_START) idle_q <= '0;
        end
      end
      out_v_q <= out_load || (out_v_q && !out_ready_i);
      if (start_err) begin
        kind_q <= KIND_ERROR; fld_q <= 1'b0; last_q <= 1'b1;
      end
      case (sc_q)
        S_IDLE: if (start_scan) begin comma_q <= '0; sub_q <= '0; pre_q <= '0; end
        S_READ: begin
          if (pre_q < 4'd11) pre_q <= pre_q + 4'd1;
          else if (!sts_i.ptr_done && sts_i.head_comma) begin
            if (comma_q != 4'd13) comma_q <= comma_q + 4'd1;
            sub_q <= '0;
          end
        end
        S_EMIT: if (!out_v_q || out_ready_i) begin
          kind_q <= KIND_FIELD; fld_q <= 1'b1; last_q <= 1'b0;
          sub_q <= has_more_i ? sub_q + 2'd1 : 2'd0;
        end
        S_TAIL: if (!out_v_q || out_ready_i) begin
          kind_q <= KIND_DONE; fld_q <= 1'b0; last_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = kind_q;
  assign use_field_o = fld_q;
  assign last_o      = last_q;

  `ASSERT_IMPL(a_no_accept_scan, clk_i, rst_ni, sc_q != S_IDLE, !in_ready_o)
  `ASSERT_NEXT(a_err_out, clk_i, rst_ni, start_err, out_valid_o && last_o)
  `ASSERT_IMPL(a_sub_range, clk_i, rst_ni, sc_q == S_EMIT, comma_q <= 4'd12)
endmodule

// File: rtl/nmea_gga_sentence_receiver_top.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_receiver_top
// NMEA 0183 GGA receiver: frames sentences, checks checksum, scans fields.
// ----------------------------------------------------------------------------
//  channel  | signals                               | dir
//  in       | in_valid_i/in_ready_o, req_type, byte | in
//  out      | out_valid_o/out_ready_i, kind,id,val  | out
//  cfg      | cfg_we_i, cfg_wdata_i (timeout ticks) | in
//
// The final checksum beat starts a scan of the sentence store if the checksum
// matches, else it loads an error beat. The scan moves one byte per cycle
// through an 11-byte window unless a result beat is being emitted; output stalls
// hold the scan. No input beat is taken during the scan or while a result is
// held. Reset is asynchronous, active low; the store is not cleared.
module nmea_gga_sentence_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [4:0]  field_id_o,
  output logic [15:0] field_value_o,
  output logic        last_o
);
  import ngga_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [3:0] comma;
  logic [1:0] sub;
  logic has_more, emits, use_fld;
  logic [4:0] fid;
  logic [15:0] fval;
  logic [4:0] fid_q;
  logic [15:0] fval_q;

  ngga_datapath u_dp (
    .clk_i, .rst_ni, .rx_byte_i, .cmd_i(cmd), .comma_i(comma), .sub_i(sub),
    .sts_o(sts), .field_id_o(fid), .field_value_o(fval),
    .has_more_o(has_more), .emits_o(emits)
  );

  ngga_controller u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .rx_byte_i,
    .cfg_we_i, .cfg_wdata_i, .cmd_o(cmd), .sts_i(sts), .comma_o(comma),
    .sub_o(sub), .has_more_i(has_more), .emits_i(emits),
    .out_valid_o, .out_ready_i, .kind_o(result_kind_o), .use_field_o(use_fld),
    .last_o
  );

  // capture field payload when a field beat is loaded
  always_ff @(posedge clk_i) begin
    if (!out_valid_o || out_ready_i) begin
      fid_q  <= fid;
      fval_q <= fval;
    end
  end
  assign field_id_o    = use_fld ? fid_q  : 5'd0;
  assign field_value_o = use_fld ? fval_q : 16'd0;
endmodule
